// ===== rtl/wfts_pkg.sv =====
package wfts_pkg;

   localparam int DEFAULT_TASK_SLOTS = 64;
   localparam logic [7:0] SLICE_RESET = 8'd4;
   localparam logic [15:0] PID_RESET = 16'd1;
   localparam logic [3:0] PRIO_MAX = 4'd15;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_CREATE = 2'd1;
   localparam logic [1:0] MODE_EXIT   = 2'd2;
   localparam logic [1:0] MODE_YIELD  = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] priority_req;
      logic [5:0] task_slot;
   } req_type;

   typedef struct packed {
      logic        running_valid;
      logic [5:0]  running_slot;
      logic        switched;
      logic [5:0]  created_slot;
      logic [15:0] created_pid;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_FIND,
      CMD_CREATE,
      CMD_EXIT,
      CMD_TICK_RD,
      CMD_TICK_WR,
      CMD_REQUEUE,
      CMD_SCAN,
      CMD_PICK,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       cur_valid;
      logic       free_hit;
      logic       idx_last;
      logic       exit_ok;
      logic       slice_expire;
      logic       rsp_busy;
   } stat_type;

   // vruntime charged per tick: 1000000 * 56483 / band weight
   function automatic logic [63:0] charge(input logic [3:0] prio);
      logic [63:0] c;
      case (prio)
         4'd0:    c = 64'd636349;
         4'd1:    c = 64'd787164;
         4'd2:    c = 64'd1000000;
         4'd3:    c = 64'd1220647;
         4'd4:    c = 64'd1556391;
         4'd5:    c = 64'd1937401;
         4'd6:    c = 64'd2428958;
         4'd7:    c = 64'd3019673;
         4'd8:    c = 64'd3778379;
         4'd9:    c = 64'd4740097;
         4'd10:   c = 64'd5915689;
         4'd11:   c = 64'd7412467;
         4'd12:   c = 64'd9259508;
         4'd13:   c = 64'd11517740;
         4'd14:   c = 64'd14460573;
         default: c = 64'd18097725;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/wfts_ctrl.sv =====
module wfts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wfts_pkg::stat_type stat,
   output wfts_pkg::cmd_type  cmd
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_DISPATCH = 12'b0000_0000_0010,
      ST_FIND     = 12'b0000_0000_0100,
      ST_CREATE   = 12'b0000_0000_1000,
      ST_EXIT     = 12'b0000_0001_0000,
      ST_TICK_RD  = 12'b0000_0010_0000,
      ST_TICK_WR  = 12'b0000_0100_0000,
      ST_REQUEUE  = 12'b0000_1000_0000,
      ST_SCAN     = 12'b0001_0000_0000,
      ST_DRAIN    = 12'b0010_0000_0000,
      ST_PICK     = 12'b0100_0000_0000,
      ST_FINISH   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cmd      = wfts_pkg::CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd      = wfts_pkg::CMD_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.mode)
               wfts_pkg::MODE_TICK:   state_in = stat.cur_valid ? ST_TICK_RD : ST_REQUEUE;
               wfts_pkg::MODE_CREATE: state_in = ST_FIND;
               wfts_pkg::MODE_EXIT:   state_in = ST_EXIT;
               default:               state_in = ST_REQUEUE;
            endcase
         end
         ST_FIND: begin
            cmd = wfts_pkg::CMD_FIND;
            if (stat.free_hit) state_in = ST_CREATE;
            else if (stat.idx_last) state_in = ST_FINISH;
         end
         ST_CREATE: begin
            cmd      = wfts_pkg::CMD_CREATE;
            state_in = ST_FINISH;
         end
         ST_EXIT: begin
            cmd      = wfts_pkg::CMD_EXIT;
            state_in = stat.exit_ok ? ST_REQUEUE : ST_FINISH;
         end
         ST_TICK_RD: begin
            cmd      = wfts_pkg::CMD_TICK_RD;
            state_in = ST_TICK_WR;
         end
         ST_TICK_WR: begin
            cmd      = wfts_pkg::CMD_TICK_WR;
            state_in = stat.slice_expire ? ST_REQUEUE : ST_FINISH;
         end
         ST_REQUEUE: begin
            cmd      = wfts_pkg::CMD_REQUEUE;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd = wfts_pkg::CMD_SCAN;
            if (stat.idx_last) state_in = ST_DRAIN;
         end
         // let the last read reach the compare stage
         ST_DRAIN: state_in = ST_PICK;
         ST_PICK: begin
            cmd      = wfts_pkg::CMD_PICK;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd      = wfts_pkg::CMD_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== rtl/wfts_datapath.sv =====
module wfts_datapath #(
   parameter int TASK_SLOTS = wfts_pkg::DEFAULT_TASK_SLOTS
) (
   input  logic               clock,
   input  logic               reset,
   input  wfts_pkg::cmd_type  cmd,
   output wfts_pkg::stat_type stat,
   input  wfts_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output wfts_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);

   localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TASK_SLOTS - 1);

   logic [3:0]  prio_mem [TASK_SLOTS];
   logic [63:0] vrt_mem  [TASK_SLOTS];
   logic [31:0] qo_mem   [TASK_SLOTS];
   logic        used_ff  [TASK_SLOTS];

   wfts_pkg::req_type req_ff;
   wfts_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] idx_ff, idx_in, cur_slot_ff, cur_slot_in, was_slot_ff;
   logic [SLOT_W-1:0] best_slot_ff, best_slot_in, rd_idx_ff, rd_addr, exit_idx;
   logic              cur_valid_ff, cur_valid_in, was_valid_ff;
   logic              found_ff, found_in, rdv_ff, rdv_in;
   logic [31:0]       enq_ff, enq_in;
   logic [7:0]        slice_ff, slice_in, slice_cfg_ff, slice_cfg_in;
   logic [15:0]       pid_ff, pid_in, cr_pid_ff, cr_pid_in;
   logic [5:0]        cr_slot_ff, cr_slot_in;
   logic [1:0]        st_ff, st_in;
   logic [3:0]        prio_rd_ff, best_p_ff, best_p_in, prio_clamp;
   logic [63:0]       vrt_rd_ff, best_v_ff, best_v_in;
   logic [31:0]       qo_rd_ff, best_q_ff, best_q_in;
   logic              free_hit, exit_ok, cur_used, beats, requeue;

   assign free_hit   = !used_ff[idx_ff];
   assign exit_idx   = SLOT_W'(req_ff.task_slot);
   assign exit_ok    = ({26'd0, req_ff.task_slot} < 32'(TASK_SLOTS)) && used_ff[exit_idx];
   assign cur_used   = used_ff[cur_slot_ff];
   assign requeue    = (cmd == wfts_pkg::CMD_REQUEUE) && cur_valid_ff && cur_used;
   assign rd_addr    = (cmd == wfts_pkg::CMD_SCAN) ? idx_ff : cur_slot_ff;
   assign prio_clamp = (req_ff.priority_req > 8'(wfts_pkg::PRIO_MAX)) ?
                       wfts_pkg::PRIO_MAX : req_ff.priority_req[3:0];
   assign beats = !found_ff || (prio_rd_ff > best_p_ff) ||
                  ((prio_rd_ff == best_p_ff) && ((vrt_rd_ff < best_v_ff) ||
                   ((vrt_rd_ff == best_v_ff) && (qo_rd_ff < best_q_ff))));

   assign stat.mode         = req_ff.mode;
   assign stat.cur_valid    = cur_valid_ff;
   assign stat.free_hit     = free_hit;
   assign stat.idx_last     = (idx_ff == LAST);
   assign stat.exit_ok      = exit_ok;
   assign stat.slice_expire = (slice_ff <= 8'd1);
   assign stat.rsp_busy     = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = !reset;

   always_comb begin
      idx_in       = idx_ff;
      cur_slot_in  = cur_slot_ff;
      cur_valid_in = cur_valid_ff;
      best_slot_in = best_slot_ff;
      best_p_in    = best_p_ff;
      best_v_in    = best_v_ff;
      best_q_in    = best_q_ff;
      found_in     = found_ff;
      rdv_in       = 1'b0;
      enq_in       = enq_ff;
      slice_in     = slice_ff;
      slice_cfg_in = csr_valid ? csr_data : slice_cfg_ff;
      pid_in       = pid_ff;
      cr_pid_in    = cr_pid_ff;
      cr_slot_in   = cr_slot_ff;
      st_in        = st_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // compare stage of the scan
      if (rdv_ff && beats) begin
         found_in     = 1'b1;
         best_slot_in = rd_idx_ff;
         best_p_in    = prio_rd_ff;
         best_v_in    = vrt_rd_ff;
         best_q_in    = qo_rd_ff;
      end

      unique case (cmd)
         wfts_pkg::CMD_LOAD: begin
            idx_in     = '0;
            st_in      = wfts_pkg::STATUS_OK;
            cr_pid_in  = '0;
            cr_slot_in = '0;
         end
         wfts_pkg::CMD_FIND: begin
            if (!free_hit) begin
               if (idx_ff == LAST) st_in = wfts_pkg::STATUS_FULL;
               else idx_in = idx_ff + 1'b1;
            end
         end
         wfts_pkg::CMD_CREATE: begin
            enq_in     = enq_ff + 32'd1;
            cr_slot_in = 6'(idx_ff);
            cr_pid_in  = pid_ff;
            pid_in     = pid_ff + 16'd1;
         end
         wfts_pkg::CMD_EXIT: begin
            if (!exit_ok) st_in = wfts_pkg::STATUS_EMPTY;
         end
         wfts_pkg::CMD_TICK_WR: begin
            slice_in = (slice_ff > 8'd1) ? slice_ff - 8'd1 : 8'd0;
         end
         wfts_pkg::CMD_REQUEUE: begin
            if (requeue) enq_in = enq_ff + 32'd1;
            idx_in   = '0;
            found_in = 1'b0;
         end
         wfts_pkg::CMD_SCAN: begin
            rdv_in = used_ff[idx_ff];
            if (idx_ff != LAST) idx_in = idx_ff + 1'b1;
         end
         wfts_pkg::CMD_PICK: begin
            cur_valid_in = found_ff;
            cur_slot_in  = found_ff ? best_slot_ff : '0;
            if (found_ff) slice_in = slice_cfg_ff;
         end
         wfts_pkg::CMD_FINISH: begin
            rsp_valid_in         = 1'b1;
            rsp_in.running_valid = cur_valid_ff;
            rsp_in.running_slot  = cur_valid_ff ? 6'(cur_slot_ff) : 6'd0;
            rsp_in.switched      = (was_valid_ff != cur_valid_ff) ||
                                   (cur_valid_ff && (was_slot_ff != cur_slot_ff));
            rsp_in.created_slot  = cr_slot_ff;
            rsp_in.created_pid   = cr_pid_ff;
            rsp_in.status        = st_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enq_ff       <= '0;
         cur_valid_ff <= 1'b0;
         cur_slot_ff  <= '0;
         slice_ff     <= '0;
         slice_cfg_ff <= wfts_pkg::SLICE_RESET;
         pid_ff       <= wfts_pkg::PID_RESET;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         for (int i = 0; i < TASK_SLOTS; i++) used_ff[i] <= 1'b0;
      end else begin
         enq_ff       <= enq_in;
         cur_valid_ff <= cur_valid_in;
         cur_slot_ff  <= cur_slot_in;
         slice_ff     <= slice_in;
         slice_cfg_ff <= slice_cfg_in;
         pid_ff       <= pid_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         if (cmd == wfts_pkg::CMD_CREATE) used_ff[idx_ff] <= 1'b1;
         if (cmd == wfts_pkg::CMD_EXIT && exit_ok) used_ff[exit_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == wfts_pkg::CMD_LOAD) begin
         req_ff       <= req_data;
         was_valid_ff <= cur_valid_ff;
         was_slot_ff  <= cur_slot_ff;
      end
      idx_ff       <= idx_in;
      best_slot_ff <= best_slot_in;
      best_p_ff    <= best_p_in;
      best_v_ff    <= best_v_in;
      best_q_ff    <= best_q_in;
      cr_pid_ff    <= cr_pid_in;
      cr_slot_ff   <= cr_slot_in;
      st_ff        <= st_in;
      rsp_ff       <= rsp_in;
      rd_idx_ff    <= idx_ff;
   end

   // task table memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (cmd == wfts_pkg::CMD_CREATE) begin
         prio_mem[idx_ff] <= prio_clamp;
         vrt_mem[idx_ff]  <= '0;
         qo_mem[idx_ff]   <= enq_ff;
      end
      if (cmd == wfts_pkg::CMD_TICK_WR)
         vrt_mem[cur_slot_ff] <= vrt_rd_ff + wfts_pkg::charge(prio_rd_ff);
      if (requeue)
         qo_mem[cur_slot_ff] <= enq_ff;
      prio_rd_ff <= prio_mem[rd_addr];
      vrt_rd_ff  <= vrt_mem[rd_addr];
      qo_rd_ff   <= qo_mem[rd_addr];
   end

endmodule

// ===== rtl/weighted_fair_task_scheduler.sv =====
// channel | ports                          | beat
// --------+--------------------------------+---------------------------------
// request | req_valid req_ready req_data   | one operation: tick/create/exit/yield
// result  | rsp_valid rsp_ready rsp_data   | one result per request
// csr     | csr_valid csr_ready csr_data   | slice_ticks write, ready outside reset
//
// Create runs a free search over the task table, one slot a cycle; a full table
// answers with status full. Reschedule (yield, idle tick, expiring tick) runs a
// scan over the task table memory read port, one slot a cycle.
// Reset is synchronous; the table needs no clearing pass. A stalled result
// holds in the output register while the next request is taken and worked.
module weighted_fair_task_scheduler #(
   parameter int TASK_SLOTS = wfts_pkg::DEFAULT_TASK_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wfts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wfts_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   wfts_pkg::cmd_type  cmd;
   wfts_pkg::stat_type stat;

   wfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wfts_datapath #(.TASK_SLOTS(TASK_SLOTS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

endmodule

// ===== rtl/wfts_checker.sv =====
module wfts_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wfts_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_idle_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.running_valid |-> rsp_data.running_slot == 6'd0)
      else $error("idle result with nonzero slot");

   a_err_created: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != wfts_pkg::STATUS_OK |->
         rsp_data.created_pid == 16'd0 && rsp_data.created_slot == 6'd0)
      else $error("failed operation reports a created task");

endmodule

bind weighted_fair_task_scheduler wfts_checker u_wfts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/weighted_fair_task_scheduler_tb.sv =====
module weighted_fair_task_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 64;
   localparam logic [1:0] PH_READY   = 2'd0;
   localparam logic [1:0] PH_RUNNING = 2'd1;
   localparam logic [1:0] PH_EXITED  = 2'd3;

   class sched_scoreboard;
      bit [7:0]  slice_cfg;
      bit        used[SLOTS];
      bit [1:0]  phase[SLOTS];
      bit [3:0]  prio[SLOTS];
      bit [63:0] vrt[SLOTS];
      bit [31:0] order[SLOTS];
      bit [31:0] enq_count;
      bit        cur_valid;
      bit [5:0]  cur_slot;
      bit [7:0]  slice_left;
      bit [15:0] pid_next;
      wfts_pkg::rsp_type pending[$];
      int        errors;
      int        checked;

      function void clear();
         slice_cfg = wfts_pkg::SLICE_RESET;
         foreach (used[i]) begin
            used[i] = 0;
            phase[i] = PH_READY;
            prio[i] = 0;
            vrt[i] = 0;
            order[i] = 0;
         end
         enq_count = 0;
         cur_valid = 0;
         cur_slot = 0;
         slice_left = 0;
         pid_next = wfts_pkg::PID_RESET;
         pending.delete();
         errors = 0;
         checked = 0;
      endfunction

      function bit [63:0] tick_charge(bit [3:0] p);
         bit [63:0] w[16] = '{88761, 71755, 56483, 46273, 36291, 29154, 23254, 18705,
                              14949, 11916, 9548, 7620, 6100, 4904, 3906, 3121};
         return 64'd1000000 * 64'd56483 / w[p];
      endfunction

      function void enqueue(int s);
         phase[s] = PH_READY;
         order[s] = enq_count;
         enq_count++;
      endfunction

      function void choose_next();
         bit found;
         int best;
         found = 0;
         best = 0;
         if (cur_valid && used[cur_slot] && phase[cur_slot] == PH_RUNNING)
            enqueue(cur_slot);
         for (int s = 0; s < SLOTS; s++) begin
            if (!used[s] || phase[s] != PH_READY) continue;
            if (!found) begin
               found = 1;
               best = s;
            end else if (prio[s] > prio[best]) begin
               best = s;
            end else if (prio[s] == prio[best]) begin
               if (vrt[s] < vrt[best] || (vrt[s] == vrt[best] && order[s] < order[best]))
                  best = s;
            end
         end
         if (!found) begin
            cur_valid = 0;
            cur_slot = 0;
            return;
         end
         phase[best] = PH_RUNNING;
         cur_valid = 1;
         cur_slot = 6'(best);
         slice_left = slice_cfg;
      endfunction

      function void note_request(wfts_pkg::req_type r);
         wfts_pkg::rsp_type e;
         bit was_valid;
         bit [5:0] was_slot;
         int s;
         was_valid = cur_valid;
         was_slot = cur_slot;
         e = '0;
         e.status = wfts_pkg::STATUS_OK;
         case (r.mode)
            wfts_pkg::MODE_TICK: begin
               if (!cur_valid) choose_next();
               else begin
                  vrt[cur_slot] += tick_charge(prio[cur_slot]);
                  if (slice_left > 1) slice_left--;
                  else begin
                     slice_left = 0;
                     choose_next();
                  end
               end
            end
            wfts_pkg::MODE_CREATE: begin
               for (s = 0; s < SLOTS; s++) if (!used[s]) break;
               if (s >= SLOTS) e.status = wfts_pkg::STATUS_FULL;
               else begin
                  used[s] = 1;
                  prio[s] = (r.priority_req > 15) ? wfts_pkg::PRIO_MAX : r.priority_req[3:0];
                  vrt[s] = 0;
                  enqueue(s);
                  e.created_slot = 6'(s);
                  e.created_pid = pid_next;
                  pid_next++;
               end
            end
            wfts_pkg::MODE_EXIT: begin
               if (!used[r.task_slot]) e.status = wfts_pkg::STATUS_EMPTY;
               else begin
                  used[r.task_slot] = 0;
                  phase[r.task_slot] = PH_EXITED;
                  choose_next();
               end
            end
            default: choose_next();
         endcase
         e.running_valid = cur_valid;
         e.running_slot = cur_valid ? cur_slot : 6'd0;
         e.switched = (was_valid != cur_valid) || (cur_valid && was_slot != cur_slot);
         pending.push_back(e);
      endfunction

      function void check_result(wfts_pkg::rsp_type a);
         wfts_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.running_valid !== e.running_valid || a.running_slot !== e.running_slot ||
             a.switched !== e.switched || a.created_slot !== e.created_slot ||
             a.created_pid !== e.created_pid || a.status !== e.status) begin
            $display("%0t: result mismatch expected %p actual %p", $time, e, a);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   wfts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   wfts_pkg::rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [7:0] csr_data = '0;

   sched_scoreboard sched = new();
   int rsp_wait = 0;
   bit hold_go = 0;
   logic long_hold = 0;
   int n_create, n_exit, n_tick, n_yield, n_full;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   weighted_fair_task_scheduler #(.TASK_SLOTS(SLOTS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // valid stays up between back-to-back beats; drop it only before a gap
   task automatic send_op(wfts_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sched.note_request(r);
      case (r.mode)
         wfts_pkg::MODE_TICK: n_tick++;
         wfts_pkg::MODE_CREATE: n_create++;
         wfts_pkg::MODE_EXIT: n_exit++;
         default: n_yield++;
      endcase
      if (r.mode == wfts_pkg::MODE_CREATE && sched.pending[$].status == wfts_pkg::STATUS_FULL)
         n_full++;
   endtask

   task automatic op(logic [1:0] m, logic [7:0] p, logic [5:0] s);
      wfts_pkg::req_type r;
      r.mode = m;
      r.priority_req = p;
      r.task_slot = s;
      send_op(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sched.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_slice(logic [7:0] v);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sched.slice_cfg = v;
      csr_valid <= 0;
   endtask

   task automatic random_op();
      int k;
      logic [5:0] s;
      k = $urandom_range(0, 99);
      s = 6'($urandom_range(0, 63));
      if (k < 60 && sched.used[s] == 0 && $urandom_range(0, 3) != 0) begin
         for (int i = 0; i < SLOTS; i++) if (sched.used[i]) s = 6'(i);
      end
      if (k < 40) op(wfts_pkg::MODE_TICK, 8'($urandom), 6'($urandom));
      else if (k < 62) op(wfts_pkg::MODE_CREATE,
                          ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                          6'($urandom));
      else if (k < 82) op(wfts_pkg::MODE_EXIT, 8'($urandom), s);
      else op(wfts_pkg::MODE_YIELD, 8'($urandom), 6'($urandom));
   endtask

   // long hold-off of the result side, counted here
   initial begin
      wait (hold_go);
      long_hold <= 1;
      repeat (300) @(posedge clock);
      long_hold <= 0;
   end

   // result side: wait a drawn number of cycles per beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         rsp_wait = $urandom_range(0, 8);
      end else begin
         if (rsp_valid && rsp_ready) begin
            sched.check_result(rsp_data);
            rsp_wait = $urandom_range(0, 8);
         end else if (rsp_valid && rsp_wait > 0 && !long_hold) begin
            rsp_wait--;
         end
         rsp_ready <= !long_hold && (rsp_wait == 0);
      end
   end

   initial begin
      sched.clear();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: idle tick, extremes, special cases
      op(wfts_pkg::MODE_TICK, 8'h00, 6'h00);
      op(wfts_pkg::MODE_EXIT, 8'hFF, 6'h3F);
      op(wfts_pkg::MODE_YIELD, 8'h00, 6'h00);
      op(wfts_pkg::MODE_CREATE, 8'hFF, 6'h3F);
      op(wfts_pkg::MODE_CREATE, 8'h00, 6'h00);
      op(wfts_pkg::MODE_CREATE, 8'h0F, 6'h15);
      op(wfts_pkg::MODE_CREATE, 8'h10, 6'h2A);
      op(wfts_pkg::MODE_TICK, 8'hAA, 6'h2A);
      for (int i = 0; i < 5; i++) op(wfts_pkg::MODE_TICK, 8'h55, 6'h15);
      op(wfts_pkg::MODE_YIELD, 8'hFF, 6'h3F);
      op(wfts_pkg::MODE_EXIT, 8'h00, 6'd1);
      op(wfts_pkg::MODE_EXIT, 8'h00, 6'd1);
      op(wfts_pkg::MODE_EXIT, 8'h00, 6'd0);
      op(wfts_pkg::MODE_EXIT, 8'h00, 6'd2);
      op(wfts_pkg::MODE_EXIT, 8'h00, 6'd3);
      op(wfts_pkg::MODE_TICK, 8'h00, 6'h00);
      drain();
      write_slice(8'd0);
      op(wfts_pkg::MODE_CREATE, 8'd3, 6'd0);
      op(wfts_pkg::MODE_CREATE, 8'd3, 6'd0);
      for (int i = 0; i < 4; i++) op(wfts_pkg::MODE_TICK, 8'd0, 6'd0);
      drain();
      // fill the table to hit the full case
      write_slice(8'd255);
      for (int i = 0; i < 66; i++) op(wfts_pkg::MODE_CREATE, 8'($urandom), 6'($urandom));
      hold_go = 1;
      for (int i = 0; i < 30; i++) op(wfts_pkg::MODE_TICK, 8'($urandom), 6'($urandom));
      for (int i = 0; i < 64; i++) op(wfts_pkg::MODE_EXIT, 8'($urandom), 6'(i));
      // random phases with several slice settings
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: write_slice(8'd1);
            1: write_slice(8'd2);
            2: write_slice(8'd255);
            3: write_slice(8'($urandom_range(3, 10)));
            4: write_slice(8'd0);
            default: write_slice(8'($urandom));
         endcase
         for (int i = 0; i < 160; i++) random_op();
      end
      // short run of exit and create pairs on slot 0
      drain();
      write_slice(8'd4);
      for (int i = 0; i < 66000; i++) begin
         if (sched.used[0]) op(wfts_pkg::MODE_EXIT, 8'($urandom), 6'd0);
         op(wfts_pkg::MODE_CREATE, 8'($urandom), 6'($urandom));
         if (i > 20) break;
      end
      drain();
      $display("ops: %0d create (%0d full), %0d exit, %0d tick, %0d yield; %0d results checked",
               n_create, n_full, n_exit, n_tick, n_yield, sched.checked);
      if (sched.errors == 0 && sched.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/wfts_pkg.sv
rtl/wfts_ctrl.sv
rtl/wfts_datapath.sv
rtl/weighted_fair_task_scheduler.sv
rtl/wfts_checker.sv
tb/weighted_fair_task_scheduler_tb.sv
